/* rtl/core/fcbp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fcbp_pkg: shared types for the framed command byte parser
// Frame phases, event codes and the classified word that the front passes on.
// ----------------------------------------------------------------------------
package fcbp_pkg;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_TYPE   = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_DATA   = 3'd4,
        PH_CHECK  = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_ANGLE     = 3'd1,
        EV_COMMAND   = 3'd2,
        EV_BAD_SUM   = 3'd3,
        EV_IGNORED   = 3'd4,
        EV_LEN_ABORT = 3'd5
    } t_event;

    typedef struct packed {
        t_event     evt;
        logic [7:0] joint_id;
        logic [7:0] angle;
        logic [7:0] command_code;
    } t_rec;

endpackage
`default_nettype wire

/* rtl/core/fcbp_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fcbp_in_if: received byte channel
// Valid/ready channel carrying one serial byte per word.
// ----------------------------------------------------------------------------
interface fcbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

/* rtl/core/fcbp_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fcbp_out_if: parser event channel
// Valid/ready channel carrying one event word per received byte.
// ----------------------------------------------------------------------------
interface fcbp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] joint_id;
    logic [7:0] angle;
    logic [7:0] command_code;
    logic       control_mode;

    modport source (output valid, output event_res, output joint_id, output angle,
                    output command_code, output control_mode, input ready);
    modport sink   (input valid, input event_res, input joint_id, input angle,
                    input command_code, input control_mode, output ready);
endinterface
`default_nettype wire

/* rtl/core/fcbp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fcbp_front: frame tracker
// Hunts for the header, collects length, payload and checksum, and turns every
// received byte into one classified event word.
// ----------------------------------------------------------------------------
module fcbp_front #(
    parameter int PAYLOAD_KEPT = 3,
    parameter int MAX_LENGTH   = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire logic [7:0]    i_cfg_wr_data,
    fcbp_in_if.sink            i_rx,
    output logic               o_push_valid,
    output fcbp_pkg::t_rec     o_push_rec,
    input  wire logic          i_push_ready
);
    import fcbp_pkg::*;

    localparam int CW = $clog2(MAX_LENGTH + 1);

    t_phase          r_phase, n_phase;
    logic [7:0]      r_header;
    logic [7:0]      r_len_hi, n_len_hi;
    logic [CW-1:0]   r_frame_len, n_frame_len;
    logic [CW-1:0]   r_count, n_count;
    logic [7:0]      r_sum, n_sum;
    logic [7:0]      r_store [PAYLOAD_KEPT];
    logic [7:0]      n_store [PAYLOAD_KEPT];
    logic            accept;
    logic [15:0]     full_len;
    logic [CW-1:0]   count_inc;
    logic [7:0]      sum_add;
    t_rec            rec;

    assign accept       = i_rx.valid && i_push_ready;
    assign i_rx.ready   = i_push_ready;
    assign o_push_valid = i_rx.valid;
    assign o_push_rec   = rec;
    assign full_len     = {r_len_hi, i_rx.rx_byte};
    assign count_inc    = r_count + CW'(1);
    assign sum_add      = r_sum + i_rx.rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= 8'hFD;
        end else if (i_cfg_wr_en) begin
            r_header <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_len_hi    <= '0;
            r_frame_len <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            for (int k = 0; k < PAYLOAD_KEPT; k++) begin
                r_store[k] <= '0;
            end
        end else if (accept) begin
            r_phase     <= n_phase;
            r_len_hi    <= n_len_hi;
            r_frame_len <= n_frame_len;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_store     <= n_store;
        end
    end

    always_comb begin
        n_phase          = r_phase;
        n_len_hi         = r_len_hi;
        n_frame_len      = r_frame_len;
        n_count          = r_count;
        n_sum            = r_sum;
        n_store          = r_store;
        rec.evt          = EV_NONE;
        rec.joint_id     = '0;
        rec.angle        = '0;
        rec.command_code = '0;
        unique case (r_phase)
            PH_TYPE: begin
                n_phase = (i_rx.rx_byte != 8'd0) ? PH_LEN_HI : PH_HUNT;
            end
            PH_LEN_HI: begin
                n_sum    = sum_add;
                n_len_hi = i_rx.rx_byte;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_sum = sum_add;
                if (full_len == 16'd0 || full_len > 16'(MAX_LENGTH)) begin
                    rec.evt = EV_LEN_ABORT;
                    n_phase = PH_HUNT;
                end else begin
                    n_frame_len = full_len[CW-1:0];
                    n_phase     = PH_DATA;
                end
            end
            PH_DATA: begin
                n_sum = sum_add;
                for (int k = 0; k < PAYLOAD_KEPT; k++) begin
                    if (32'(r_count) == k) begin
                        n_store[k] = i_rx.rx_byte;
                    end
                end
                n_count = count_inc;
                if (count_inc >= r_frame_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                // dispatch on the first three payload bytes
                if (r_sum != i_rx.rx_byte) begin
                    rec.evt = EV_BAD_SUM;
                end else if ((r_store[0] | r_store[1]) != 8'd0 && r_store[2] == 8'd0) begin
                    rec.evt      = EV_ANGLE;
                    rec.joint_id = r_store[0];
                    rec.angle    = r_store[1];
                end else if ((r_store[0] | r_store[1]) == 8'd0 && r_store[2] != 8'd0) begin
                    rec.evt          = EV_COMMAND;
                    rec.command_code = r_store[2];
                end else begin
                    rec.evt = EV_IGNORED;
                end
                n_phase = PH_HUNT;
            end
            default: begin
                n_frame_len = '0;
                n_count     = '0;
                n_sum       = '0;
                n_phase     = (i_rx.rx_byte == r_header) ? PH_TYPE : PH_HUNT;
            end
        endcase
    end

    a_count_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_count < r_frame_len)
        else $error("payload count reached frame length in data phase");

    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_frame_len != '0 && 32'(r_frame_len) <= MAX_LENGTH)
        else $error("frame length out of range in data phase");

endmodule
`default_nettype wire

/* rtl/core/fcbp_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fcbp_queue: two-word event queue
// Decouples the frame tracker from the dispatch stage.
// ----------------------------------------------------------------------------
module fcbp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    input  fcbp_pkg::t_rec     i_push_rec,
    output logic               o_push_ready,
    output logic               o_pop_valid,
    output fcbp_pkg::t_rec     o_pop_rec,
    input  wire logic          i_pop_ready
);
    import fcbp_pkg::*;

    localparam logic [1:0] DEPTH = 2'd2;

    t_rec       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       push, pop;

    assign o_push_ready = (r_count != DEPTH);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_rec    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_rec;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH)
        else $error("event queue over capacity");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) == (r_wr_ptr != r_rd_ptr))
        else $error("event queue pointers disagree with count");

endmodule
`default_nettype wire

/* rtl/core/fcbp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fcbp_back: dispatch stage
// Applies each event word to the mode flag and holds it in the output register.
// ----------------------------------------------------------------------------
module fcbp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_pop_valid,
    input  fcbp_pkg::t_rec     i_pop_rec,
    output logic               o_pop_ready,
    fcbp_out_if.source         o_ev
);
    import fcbp_pkg::*;

    logic r_valid, n_valid;
    t_rec r_rec;
    logic r_mode, n_mode;
    logic pop;

    assign o_pop_ready = !r_valid || o_ev.ready;
    assign pop         = i_pop_valid && o_pop_ready;

    always_comb begin
        n_valid = r_valid;
        n_mode  = r_mode;
        if (o_ev.ready) begin
            n_valid = 1'b0;
        end
        if (pop) begin
            n_valid = 1'b1;
            if (i_pop_rec.evt == EV_ANGLE) begin
                n_mode = 1'b0;
            end else if (i_pop_rec.evt == EV_COMMAND) begin
                n_mode = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mode  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_mode  <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rec <= i_pop_rec;
        end
    end

    assign o_ev.valid        = r_valid;
    assign o_ev.event_res    = r_rec.evt;
    assign o_ev.joint_id     = r_rec.joint_id;
    assign o_ev.angle        = r_rec.angle;
    assign o_ev.command_code = r_rec.command_code;
    assign o_ev.control_mode = r_mode;

    a_mode_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && (i_pop_rec.evt == EV_ANGLE || i_pop_rec.evt == EV_COMMAND))
        |=> $stable(r_mode))
        else $error("mode changed without a dispatched frame");

endmodule
`default_nettype wire

/* rtl/core/framed_command_byte_parser_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// framed_command_byte_parser_top: framed command byte parser
// Parses header/type/length/payload/checksum frames from a byte stream.
// ----------------------------------------------------------------------------
// Takes one received byte per word on i_rx and returns exactly one event word
// per byte on o_ev, in order. Sustained rate is one byte per clock while o_ev
// is ready: the frame tracker updates its phase, length, count, checksum and
// kept payload bytes. A two-word queue between the tracker and the dispatch
// stage holds each event word before the output register does. The header
// byte resets to 0xFD and is rewritten through i_cfg_wr_en/i_cfg_wr_data; the
// user must do so only while the parser is idle; the block does not check.
// control_mode gives the mode after the event's byte (0 learning, 1 control).
module framed_command_byte_parser_top #(
    parameter int PAYLOAD_KEPT = 3,
    parameter int MAX_LENGTH   = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    fcbp_in_if.sink         i_rx,
    fcbp_out_if.source      o_ev
);
    import fcbp_pkg::*;

    logic push_valid, push_ready;
    t_rec push_rec;
    logic pop_valid, pop_ready;
    t_rec pop_rec;

    fcbp_front #(
        .PAYLOAD_KEPT (PAYLOAD_KEPT),
        .MAX_LENGTH   (MAX_LENGTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rx          (i_rx),
        .o_push_valid  (push_valid),
        .o_push_rec    (push_rec),
        .i_push_ready  (push_ready)
    );

    fcbp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_rec   (push_rec),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_rec    (pop_rec),
        .i_pop_ready  (pop_ready)
    );

    fcbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_rec   (pop_rec),
        .o_pop_ready (pop_ready),
        .o_ev        (o_ev)
    );

endmodule
`default_nettype wire
